### rtl/core/rgbled_pkg.sv
package rgbled_pkg;

  // Input item kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    ACT_WRITE_ONE = 2'd0,
    ACT_WRITE_ALL = 2'd1,
    ACT_TICK      = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_DUTY_ONE   = 2'd1;
  localparam logic [1:0] REG_DUTY_ZERO  = 2'd2;

  localparam logic [6:0] BRIGHT_MAX   = 7'd100;
  localparam logic [6:0] BRIGHT_RESET = 7'd20;

  // Bit periods per LED: green, red, blue, MSB first
  localparam logic [4:0] BIT_LAST = 5'd23;

  // floor(p / 100) == (p * 5243) >> 19 for every p below 43699
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // One stored colour, red in the top byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Commands from the sequencer to the colour store
  typedef struct packed {
    logic write_one;
    logic fill_all;
  } store_cmd_t;

endpackage

### rtl/core/rgbled_store.sv
module rgbled_store
  import rgbled_pkg::*;
#(
  parameter int LED_COUNT = 64,
  parameter int AW        = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_cmd_t      cmd_i,
  input  logic [AW-1:0]   waddr_i,
  input  color_t          wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output color_t          rdata_o,
  output logic            busy_o
);

  localparam logic [AW-1:0] ADDR_LAST = AW'(LED_COUNT - 1);

  color_t        mem [LED_COUNT];
  color_t        rdata_q;
  color_t        fill_data_q, fill_data_d;
  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic          busy_q, busy_d;
  logic          we;
  logic [AW-1:0] waddr;
  color_t        wdata;

  // Sweep control: reset starts a clearing pass, a fill command starts a fill pass
  always_comb begin
    busy_d      = busy_q;
    fill_cnt_d  = fill_cnt_q;
    fill_data_d = fill_data_q;
    if (busy_q) begin
      fill_cnt_d = fill_cnt_q + AW'(1);
      if (fill_cnt_q == ADDR_LAST) begin
        busy_d     = 1'b0;
        fill_cnt_d = '0;
      end
    end else if (cmd_i.fill_all) begin
      busy_d      = 1'b1;
      fill_cnt_d  = '0;
      fill_data_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      fill_cnt_q  <= '0;
      fill_data_q <= '0;
    end else begin
      busy_q      <= busy_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_data_q <= fill_data_d;
    end
  end

  // Single write port shared by the sweep and single-entry writes
  assign we    = busy_q | cmd_i.write_one;
  assign waddr = busy_q ? fill_cnt_q : waddr_i;
  assign wdata = busy_q ? fill_data_q : wdata_i;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### rtl/core/rgbled_scaler.sv
module rgbled_scaler
  import rgbled_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] chan_i,
  input  logic [6:0] bright_i,
  output logic [7:0] scaled_o
);

  logic [14:0] prod_q;
  logic [27:0] recip;

  // Stage one: channel times brightness percent
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 15'(chan_i) * 15'(bright_i);
    end
  end

  // Stage two: divide by 100 through the reciprocal
  assign recip    = 28'(prod_q) * 28'(RECIP_100);
  assign scaled_o = recip[RECIP_SHIFT +: 8];

endmodule

### rtl/core/rgb_led_strip_bit_encoder_unit.sv
// Tick: result shows on m_axis after the memory read, then product, then reciprocal
// divide stages; the divide state waits for a free output, and no item is taken meanwhile.
// Single-LED writes and unused actions keep the input ready; a write-all sweeps the
// store one entry per cycle, with s_axis_tready low meanwhile.
// Reset is asynchronous, active low; after it a clearing pass zeroes the colour
// store, with s_axis_tready low meanwhile.
module rgb_led_strip_bit_encoder_unit
  import rgbled_pkg::*;
#(
  parameter int LED_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // led_index[9:0], red[17:10], green[25:18], blue[33:26]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // duty_value[15:0], bit_value[16], led_position[26:17]
  output logic        m_axis_tlast   // frame_end
);

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [AW-1:0] LED_LAST = AW'(LED_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [6:0]    bright_q;
  logic [15:0]   duty_one_q, duty_zero_q;
  logic [AW-1:0] led_pos_q, led_pos_d;
  logic [4:0]    bit_q, bit_d;

  logic          out_valid_q, out_valid_d;
  logic [15:0]   out_duty_q;
  logic          out_bit_q;
  logic [AW-1:0] out_led_q;
  logic          out_last_q;

  logic          in_fire;
  action_e       action;
  logic [9:0]    led_index;
  color_t        in_color;
  logic          idx_ok;
  store_cmd_t    store_cmd;
  color_t        rdata;
  logic          store_busy;
  logic [7:0]    chan;
  logic [7:0]    scaled;
  logic          cur_bit;
  logic          out_free;
  logic          load_out;
  logic          last_bit;

  // Unpack the input transaction
  assign action         = action_e'(s_axis_tuser);
  assign led_index      = s_axis_tdata[9:0];
  assign in_color.red   = s_axis_tdata[17:10];
  assign in_color.green = s_axis_tdata[25:18];
  assign in_color.blue  = s_axis_tdata[33:26];

  assign s_axis_tready = (state_q == S_IDLE) && !store_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = 11'(led_index) < 11'(LED_COUNT);

  assign store_cmd.write_one = in_fire && (action == ACT_WRITE_ONE) && idx_ok;
  assign store_cmd.fill_all  = in_fire && (action == ACT_WRITE_ALL);

  rgbled_store #(
    .LED_COUNT (LED_COUNT),
    .AW        (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (store_cmd),
    .waddr_i (led_index[AW-1:0]),
    .wdata_i (in_color),
    .raddr_i (led_pos_q),
    .rdata_o (rdata),
    .busy_o  (store_busy)
  );

  // Pick the channel for the current bit period
  always_comb begin
    case (bit_q[4:3])
      2'd0:    chan = rdata.green;
      2'd1:    chan = rdata.red;
      default: chan = rdata.blue;
    endcase
  end

  rgbled_scaler u_scaler (
    .clk_i    (clk_i),
    .en_i     (state_q == S_MUL),
    .chan_i   (chan),
    .bright_i (bright_q),
    .scaled_o (scaled)
  );

  assign cur_bit  = scaled[3'd7 - bit_q[2:0]];
  assign out_free = !out_valid_q || m_axis_tready;
  assign load_out = (state_q == S_DIV) && out_free;
  assign last_bit = (bit_q == BIT_LAST) && (led_pos_q == LED_LAST);

  // Sequence ticks and advance the stream position
  always_comb begin
    state_d   = state_q;
    led_pos_d = led_pos_q;
    bit_d     = bit_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (action == ACT_TICK)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (bit_q == BIT_LAST) begin
            bit_d     = '0;
            led_pos_d = (led_pos_q == LED_LAST) ? '0 : led_pos_q + AW'(1);
          end else begin
            bit_d = bit_q + 5'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: drop on handshake, load on a finished tick
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      led_pos_q   <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      led_pos_q   <= led_pos_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_duty_q <= cur_bit ? duty_one_q : duty_zero_q;
      out_bit_q  <= cur_bit;
      out_led_q  <= led_pos_q;
      out_last_q <= last_bit;
    end
  end

  // Configuration registers, brightness saturates at full scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= BRIGHT_RESET;
      duty_one_q  <= '0;
      duty_zero_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BRIGHTNESS: bright_q <= (cfg_wdata_i[6:0] > BRIGHT_MAX) ? BRIGHT_MAX
                                                                    : cfg_wdata_i[6:0];
        REG_DUTY_ONE:   duty_one_q  <= cfg_wdata_i;
        REG_DUTY_ZERO:  duty_zero_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, 10'(out_led_q), out_bit_q, out_duty_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/core/rgbled_checker.sv
module rgbled_checker
  import rgbled_pkg::*;
#(
  parameter int LED_COUNT = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic tick_fire;
  assign tick_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_TICK);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A fresh result is first seen after its tick transaction passes the product and divide states
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tick_fire, 3))
    else $error("result without a tick");

  // A tick blocks the input while it is worked on
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted during a tick");

  // Frame end only on the last LED
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[26:17] == 10'(LED_COUNT - 1))
    else $error("frame end on wrong LED");

endmodule

bind rgb_led_strip_bit_encoder_unit rgbled_checker #(.LED_COUNT(LED_COUNT)) u_rgbled_checker (.*);

### tb/sv/tb_rgb_led_strip_bit_encoder_unit.sv
`timescale 1ns / 100ps

module tb_rgb_led_strip_bit_encoder_unit;
  import rgbled_pkg::*;

  localparam int LEDS       = 64;
  localparam int FRAME_BITS = LEDS * 24;
  // Enough idle cycles to cover a write-all sweep of the store
  localparam int SETTLE     = LEDS + 8;

  // One bit period as it leaves the block
  typedef struct packed {
    logic        frame_end;
    logic [9:0]  led_position;
    logic        bit_value;
    logic [15:0] duty_value;
  } strip_bit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // led_index[9:0], red[17:10], green[25:18], blue[33:26]
  logic [1:0]  s_axis_tuser;   // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // duty_value[15:0], bit_value[16], led_position[26:17]
  logic        m_axis_tlast;   // frame_end

  // Predicted block state
  color_t      color_store [LEDS];
  logic [10:0] stream_pos;
  logic [6:0]  bright_pct;
  logic [15:0] duty_hi;
  logic [15:0] duty_lo;
  strip_bit_t  pending_bits [$];

  int unsigned err_count    = 0;
  int unsigned item_count   = 0;
  int unsigned result_count = 0;
  bit          calm         = 1'b0;
  int unsigned ready_hold_req  = 0;
  int unsigned ready_hold_left = 0;

  rgb_led_strip_bit_encoder_unit #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Return the store, stream and registers to their reset values
  function automatic void reset_strip();
    foreach (color_store[i]) color_store[i] = '0;
    stream_pos = '0;
    bright_pct = BRIGHT_RESET;
    duty_hi    = '0;
    duty_lo    = '0;
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [15:0] data);
    case (idx)
      REG_BRIGHTNESS: bright_pct = (data[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : data[6:0];
      REG_DUTY_ONE:   duty_hi = data;
      REG_DUTY_ZERO:  duty_lo = data;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] scale_channel(logic [7:0] v);
    int unsigned prod;
    prod = v * bright_pct;
    return 8'(prod / 100);
  endfunction

  // Compute the bit period at the stream position and advance it
  function automatic strip_bit_t next_strip_bit();
    int unsigned pos, led, slot;
    logic [7:0]  chan_val;
    logic [7:0]  scaled;
    strip_bit_t  r;
    pos  = stream_pos;
    led  = pos / 24;
    slot = pos % 24;
    case (slot / 8)
      0:       chan_val = color_store[led].green;
      1:       chan_val = color_store[led].red;
      default: chan_val = color_store[led].blue;
    endcase
    scaled         = scale_channel(chan_val);
    r.bit_value    = scaled[7 - (slot % 8)];
    r.duty_value   = r.bit_value ? duty_hi : duty_lo;
    r.led_position = 10'(led);
    r.frame_end    = (pos == FRAME_BITS - 1);
    stream_pos     = (pos == FRAME_BITS - 1) ? 11'd0 : 11'(pos + 1);
    return r;
  endfunction

  function automatic void update_strip(action_e act, logic [9:0] idx, color_t c);
    case (act)
      ACT_WRITE_ONE: if (idx < LEDS) color_store[idx] = c;
      ACT_WRITE_ALL: foreach (color_store[i]) color_store[i] = c;
      ACT_TICK:      pending_bits.push_back(next_strip_bit());
      default: ;
    endcase
  endfunction

  function automatic color_t rand_color();
    return color_t'(24'($urandom));
  endfunction

  // LED at or just after the one being streamed, so writes show up soon
  function automatic logic [9:0] near_led();
    return 10'((stream_pos / 24 + $urandom_range(0, 2)) % LEDS);
  endfunction

  function automatic void report_mismatch(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  // Offer one item and hold it until the transaction completes
  task automatic send_item(action_e act, logic [9:0] idx, color_t c);
    while (!calm && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'b0, c.blue, c.green, c.red, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    item_count++;
    update_strip(act, idx, c);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 10'($urandom), rand_color());
  endtask

  // Drop valid, wait for every expected result, then let a sweep finish
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    apply_register(idx, data);
  endtask

  // Reset brightness, ignored writes and the unused action
  task automatic test_reset_values();
    write_reg(REG_DUTY_ONE, 16'hFFFF);
    write_reg(REG_DUTY_ZERO, 16'h0000);
    send_item(ACT_WRITE_ONE, 10'd0, color_t'{red: 8'h80, green: 8'hFF, blue: 8'h01});
    send_item(ACT_WRITE_ONE, 10'h3FF, color_t'(24'hFFFFFF));
    send_item(ACT_WRITE_ONE, 10'(LEDS), color_t'(24'hFFFFFF));
    send_item(ACT_NONE, 10'h3FF, color_t'(24'hFFFFFF));
    repeat (8) send_tick();
  endtask

  // Saturation above 100, zero brightness and swapped duty extremes
  task automatic test_brightness_extremes();
    drain_results();
    write_reg(REG_BRIGHTNESS, 16'd127);
    repeat (4) send_tick();
    drain_results();
    write_reg(REG_BRIGHTNESS, 16'd0);
    write_reg(REG_DUTY_ONE, 16'h0000);
    write_reg(REG_DUTY_ZERO, 16'hFFFF);
    repeat (2) send_tick();
    drain_results();
    write_reg(REG_BRIGHTNESS, 16'd101);
    write_reg(REG_DUTY_ONE, 16'hA5C3);
    repeat (2) send_tick();
  endtask

  // Fill the whole store, then clear it with a write of zeros
  task automatic test_fill_and_clear();
    send_item(ACT_WRITE_ALL, 10'h3FF, color_t'(24'hFFFFFF));
    repeat (3) send_tick();
    send_item(ACT_WRITE_ALL, 10'h000, color_t'(24'h000000));
    repeat (3) send_tick();
  endtask

  // Give every LED its own color and stream across a few LEDs
  task automatic test_per_led_colors();
    drain_results();
    write_reg(REG_BRIGHTNESS, 16'(BRIGHT_MAX));
    write_reg(REG_DUTY_ONE, 16'($urandom));
    write_reg(REG_DUTY_ZERO, 16'($urandom));
    for (int i = 0; i < LEDS; i++) send_item(ACT_WRITE_ONE, 10'(i), rand_color());
    for (int i = 0; i < 72; i++) begin
      if ($urandom_range(0, 99) < 4) send_item(ACT_WRITE_ONE, near_led(), rand_color());
      send_tick();
    end
  endtask

  // Hold off the result side while ticks keep coming, then pause the sender
  task automatic test_backpressure();
    drain_results();
    ready_hold_req = 200;
    repeat (40) send_tick();
    drain_results();
  endtask

  // Mostly ticks, with writes aimed near the stream and some noise
  task automatic test_random_mix();
    action_e act;
    int unsigned r;
    for (int phase = 0; phase < 5; phase++) begin
      drain_results();
      calm = (phase == 3);
      case (phase)
        0:       write_reg(REG_BRIGHTNESS, 16'd0);
        1:       write_reg(REG_BRIGHTNESS, 16'd127);
        2:       write_reg(REG_BRIGHTNESS, 16'(BRIGHT_MAX));
        default: write_reg(REG_BRIGHTNESS, 16'($urandom_range(0, 127)));
      endcase
      if (phase == 2) begin
        write_reg(REG_DUTY_ONE, 16'hFFFF);
        write_reg(REG_DUTY_ZERO, 16'h0000);
      end else begin
        write_reg(REG_DUTY_ONE, 16'($urandom));
        write_reg(REG_DUTY_ZERO, 16'($urandom));
      end
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_tick();
        end else if (r < 86) begin
          send_item(ACT_WRITE_ONE, near_led(), rand_color());
        end else if (r < 92) begin
          send_item(ACT_WRITE_ONE, 10'($urandom), rand_color());
        end else if (r < 95) begin
          send_item(ACT_WRITE_ALL, 10'($urandom), rand_color());
        end else begin
          act = ACT_NONE;
          send_item(act, 10'($urandom), rand_color());
        end
      end
    end
    calm = 1'b0;
  endtask

  // Drive result-side ready: long hold on request, else random idling
  always @(posedge clk_i) begin
    if (ready_hold_req != 0) begin
      ready_hold_left = ready_hold_req;
      ready_hold_req  = 0;
    end
    if (ready_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold_left--;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    strip_bit_t got;
    strip_bit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.duty_value   = m_axis_tdata[15:0];
      got.bit_value    = m_axis_tdata[16];
      got.led_position = m_axis_tdata[26:17];
      got.frame_end    = m_axis_tlast;
      result_count++;
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected result: duty=%h bit=%b led=%0d last=%b",
                                  got.duty_value, got.bit_value, got.led_position,
                                  got.frame_end));
      end else begin
        want = pending_bits.pop_front();
        if (got.duty_value !== want.duty_value || got.bit_value !== want.bit_value ||
            got.led_position !== want.led_position || got.frame_end !== want.frame_end) begin
          report_mismatch($sformatf(
            "result %0d: expected duty=%h bit=%b led=%0d last=%b, got duty=%h bit=%b led=%0d last=%b",
            result_count, want.duty_value, want.bit_value, want.led_position, want.frame_end,
            got.duty_value, got.bit_value, got.led_position, got.frame_end));
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_BRIGHTNESS;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_NONE;
    m_axis_tready <= 1'b0;
    reset_strip();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the clearing pass
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);

    test_reset_values();
    test_brightness_extremes();
    test_fill_and_clear();
    test_per_led_colors();
    test_backpressure();
    test_random_mix();
    drain_results();

    $display("Sent %0d items and checked %0d duty values, streaming up to LED %0d,",
             item_count, result_count, stream_pos / 24);
    $display("with brightness 0..127, duty extremes, fills, clears and held-off output.");
    if (err_count == 0) begin
      $display("rgb_led_strip_bit_encoder_unit: match");
    end else begin
      $display("rgb_led_strip_bit_encoder_unit: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("rgb_led_strip_bit_encoder_unit: mismatch");
    $finish;
  end

endmodule

### rgb_led_strip_bit_encoder_unit.f
rtl/core/rgbled_pkg.sv
rtl/core/rgbled_store.sv
rtl/core/rgbled_scaler.sv
rtl/core/rgb_led_strip_bit_encoder_unit.sv
rtl/core/rgbled_checker.sv
tb/sv/tb_rgb_led_strip_bit_encoder_unit.sv
